### src/ifabd_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: shared package
// Types, codes and constants used across the filter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ifabd_pkg;

  // Largest burst the verdict buffer holds, and the default burst limit.
  localparam int MASK_W        = 32;
  localparam int BURST_MAX_DEF = 32;

  localparam int FILL_W   = 6;   // holds 0..32
  localparam int SLOT_W   = 5;
  localparam int LEN_W    = 16;
  localparam int CNT26_W  = 26;
  localparam int CNT32_W  = 32;
  localparam int CFG_W    = 26;  // widest register
  localparam int CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CNT26_W-1:0] THRESHOLD_RST = 26'd200000;
  localparam logic [LEN_W-1:0]   MIN_LEN_RST   = 16'd64;
  localparam logic [LEN_W-1:0]   MAX_LEN_RST   = 16'd1518;

  // Header field constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;   // 5 words = 20 bytes
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DROP_LEVEL      = 2'd0,
    CFG_MIN_FRAME_LEN   = 2'd1,
    CFG_MAX_FRAME_LEN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    VERD_FORWARD = 2'd0,
    VERD_INVALID = 2'd1,
    VERD_BURST   = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_ACC_INVALID,
    S_ACC_DROPPED,
    S_ACC_VALID,
    S_EMIT,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  frame_len;
    logic [15:0]       eth_type;
    logic [7:0]        ver_ihl;
    logic [7:0]        ip_proto;
    logic              burst_last;
  } in_item_t;

  typedef struct packed {
    logic                kind;
    verdict_t            verdict;
    logic [SLOT_W-1:0]   slot;
    logic                last;
    logic [CNT26_W-1:0]  interval_count;
    logic                burst_flag;
    logic [CNT32_W-1:0]  invalid_total;
    logic [CNT32_W-1:0]  dropped_total;
  } out_item_t;

endpackage

`default_nettype wire

### src/ifabd_in_if.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: input channel
// Valid/ready channel carrying one packet header or tick item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifabd_in_if;
  import ifabd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/ifabd_out_if.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: output channel
// Valid/ready channel carrying one verdict or interval report item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifabd_out_if;
  import ifabd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/ifabd_hdr_check.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: header check
// Decides whether one packet header passes the IPv4 filter rules.
// ----------------------------------------------------------------------------
`default_nettype none

module ifabd_hdr_check (
  input  wire ifabd_pkg::in_item_t        hdr,
  input  wire logic [ifabd_pkg::LEN_W-1:0] min_frame_len,
  input  wire logic [ifabd_pkg::LEN_W-1:0] max_frame_len,
  output logic                             ok
);
  import ifabd_pkg::*;

  logic len_ok;
  logic proto_ok;

  always_comb begin
    len_ok   = (hdr.frame_len >= min_frame_len) && (hdr.frame_len <= max_frame_len);
    proto_ok = hdr.ip_proto inside {PROTO_UDP, PROTO_ICMP};
    ok       = len_ok && proto_ok &&
               (hdr.eth_type == ETHERTYPE_IPV4) &&
               (hdr.ver_ihl[7:4] == IP_VERSION_4) &&
               (hdr.ver_ihl[3:0] >= IHL_MIN);
  end

endmodule

`default_nettype wire

### src/ifabd_sat_add.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: saturating adder
// The one arithmetic unit, shared by every counting step of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ifabd_sat_add (
  input  wire logic [ifabd_pkg::CNT32_W-1:0] a,
  input  wire logic [ifabd_pkg::CNT32_W-1:0] b,
  input  wire logic                          narrow,  // saturate at 26 bits
  output logic      [ifabd_pkg::CNT32_W-1:0] sum
);
  import ifabd_pkg::*;

  logic [CNT32_W:0]   raw;
  logic [CNT32_W:0]   limit;

  always_comb begin
    raw   = {1'b0, a} + {1'b0, b};
    limit = narrow ? {{(CNT32_W-CNT26_W+1){1'b0}}, {CNT26_W{1'b1}}}
                   : {1'b0, {CNT32_W{1'b1}}};
    sum   = (raw > limit) ? limit[CNT32_W-1:0] : raw[CNT32_W-1:0];
  end

endmodule

`default_nettype wire

### src/ipv4_filter_adaptive_burst_drop.sv
// ----------------------------------------------------------------------------
// IPv4 header filter with rate-triggered adaptive burst drop
// Buffers per-burst header verdicts and releases them at burst end.
// ----------------------------------------------------------------------------
// Each packet item is checked against the IPv4 rules (length bounds,
// EtherType 0x0800, version 4, IHL of at least five words, UDP or ICMP) and
// its pass bit is stored at its slot in the burst buffer; a packet that
// leaves the burst open leaves the input ready for the next packet. The
// burst closes on burst_last or when it reaches the burst limit (BURST_MAX,
// clamped to 1..32). A small sequencer then drives a single saturating
// adder: it counts the valid packets of the burst slot by slot, adds to the
// invalid total, the burst-drop total and the interval valid count in turn,
// and then the verdict items go out one per cycle while the output side
// keeps ready high. After the packet that closes a burst, the input is
// therefore not ready until the last verdict item has been taken, as the
// shared adder walks the buffer once and the output port emits once per
// slot; a stall on the output holds the input off for longer. If the drop
// flag is set when the burst closes, the first floor(v/2) of its v valid
// packets are reported as burst drops. A tick item is taken and then its
// report item is shown, held while the output stalls; it reports and
// clears the interval valid count and sets the drop flag when that count
// reached drop_level, clearing it otherwise. The input is not ready while
// a burst is being resolved or a result is waiting.
// Configuration writes are taken at any time but are meant to be made while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_filter_adaptive_burst_drop #(
  parameter int BURST_MAX = ifabd_pkg::BURST_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ifabd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ifabd_pkg::CFG_W-1:0]       cfg_data,
  ifabd_in_if.sink                               in_ch,
  ifabd_out_if.source                            out_ch
);
  import ifabd_pkg::*;

  // Effective burst limit: values outside 1..32 are clamped.
  localparam int BurstLimit = (BURST_MAX < 1) ? 1 :
                              ((BURST_MAX > MASK_W) ? MASK_W : BURST_MAX);

  // Configuration registers.
  logic [CNT26_W-1:0] drop_level;
  logic [LEN_W-1:0]   min_frame_len;
  logic [LEN_W-1:0]   max_frame_len;

  // Sequencer and datapath state.
  state_t             state, state_next;
  logic [MASK_W-1:0]  verdict_mask;
  logic [FILL_W-1:0]  burst_fill;    // packets buffered in the open burst
  logic [FILL_W-1:0]  burst_len;     // size of the burst being resolved
  logic [SLOT_W-1:0]  idx;           // slot walked by count and emit
  logic [FILL_W-1:0]  valid_cnt;     // valid packets in the closed burst
  logic [FILL_W-1:0]  seen;          // valid packets already emitted
  logic [SLOT_W-1:0]  ndrop;         // valid packets to drop in this burst
  logic [CNT26_W-1:0] valid_in_interval;
  logic               drop_active;
  logic [CNT32_W-1:0] invalid_count;
  logic [CNT32_W-1:0] dropped_count;
  logic [CNT26_W-1:0] report_count;

  logic               hdr_ok;
  logic               in_fire;
  logic               out_fire;
  logic [FILL_W-1:0]  fill_inc;
  logic               burst_end;
  logic               idx_at_end;
  logic [SLOT_W-1:0]  ndrop_calc;

  logic [CNT32_W-1:0] alu_a, alu_b, alu_sum;
  logic               alu_narrow;

  ifabd_hdr_check u_hdr_check (
    .hdr           (in_ch.data),
    .min_frame_len (min_frame_len),
    .max_frame_len (max_frame_len),
    .ok            (hdr_ok)
  );

  ifabd_sat_add u_sat_add (
    .a      (alu_a),
    .b      (alu_b),
    .narrow (alu_narrow),
    .sum    (alu_sum)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  // A burst closes on its marked last packet or when it reaches the limit.
  assign fill_inc   = burst_fill + FILL_W'(1);
  assign burst_end  = in_ch.data.burst_last || (fill_inc >= FILL_W'(BurstLimit));
  assign idx_at_end = ({1'b0, idx} == (burst_len - FILL_W'(1)));
  assign ndrop_calc = drop_active ? valid_cnt[FILL_W-1:1] : '0;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a      = '0;
    alu_b      = '0;
    alu_narrow = 1'b0;
    case (state)
      S_COUNT: begin
        alu_a = CNT32_W'(valid_cnt);
        alu_b = CNT32_W'(verdict_mask[idx]);
      end
      S_ACC_INVALID: begin
        alu_a = invalid_count;
        alu_b = CNT32_W'(burst_len - valid_cnt);
      end
      S_ACC_DROPPED: begin
        alu_a = dropped_count;
        alu_b = CNT32_W'(ndrop_calc);
      end
      S_ACC_VALID: begin
        alu_a      = CNT32_W'(valid_in_interval);
        alu_b      = CNT32_W'(valid_cnt);
        alu_narrow = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state and result item.
  always_comb begin
    state_next = state;
    out_ch.valid = 1'b0;
    out_ch.data  = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.func) begin
            state_next = S_REPORT;
          end else if (burst_end) begin
            state_next = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        if (idx_at_end) begin
          state_next = S_ACC_INVALID;
        end
      end
      S_ACC_INVALID: begin
        state_next = S_ACC_DROPPED;
      end
      S_ACC_DROPPED: begin
        state_next = S_ACC_VALID;
      end
      S_ACC_VALID: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_ch.valid              = 1'b1;
        out_ch.data.kind          = 1'b0;
        out_ch.data.slot          = idx;
        out_ch.data.last          = idx_at_end;
        out_ch.data.invalid_total = invalid_count;
        out_ch.data.dropped_total = dropped_count;
        if (!verdict_mask[idx]) begin
          out_ch.data.verdict = VERD_INVALID;
        end else if (seen < FILL_W'(ndrop)) begin
          out_ch.data.verdict = VERD_BURST;
        end else begin
          out_ch.data.verdict = VERD_FORWARD;
        end
        if (out_fire && idx_at_end) begin
          state_next = S_IDLE;
        end
      end
      S_REPORT: begin
        out_ch.valid               = 1'b1;
        out_ch.data.kind           = 1'b1;
        out_ch.data.interval_count = report_count;
        out_ch.data.burst_flag     = drop_active;
        out_ch.data.invalid_total  = invalid_count;
        out_ch.data.dropped_total  = dropped_count;
        if (out_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      drop_level      <= THRESHOLD_RST;
      min_frame_len   <= MIN_LEN_RST;
      max_frame_len   <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DROP_LEVEL:      drop_level      <= cfg_data[CNT26_W-1:0];
        CFG_MIN_FRAME_LEN:   min_frame_len   <= cfg_data[LEN_W-1:0];
        CFG_MAX_FRAME_LEN:   max_frame_len   <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Counters and flags that persist across items.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_fill        <= '0;
      valid_in_interval <= '0;
      drop_active       <= 1'b0;
      invalid_count     <= '0;
      dropped_count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.data.func) begin
              valid_in_interval <= '0;
              drop_active       <= (valid_in_interval >= drop_level);
            end else begin
              burst_fill <= burst_end ? '0 : fill_inc;
            end
          end
        end
        S_ACC_INVALID: invalid_count     <= alu_sum;
        S_ACC_DROPPED: dropped_count     <= alu_sum;
        S_ACC_VALID:   valid_in_interval <= alu_sum[CNT26_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Burst buffer and walk registers. Every slot read was written in the
  // current burst, so none of these needs a reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.func) begin
            report_count <= valid_in_interval;
          end else begin
            verdict_mask[burst_fill[SLOT_W-1:0]] <= hdr_ok;
            burst_len <= fill_inc;
            idx       <= '0;
            valid_cnt <= '0;
          end
        end
      end
      S_COUNT: begin
        valid_cnt <= alu_sum[FILL_W-1:0];
        idx       <= idx_at_end ? '0 : idx + SLOT_W'(1);
      end
      S_ACC_DROPPED: begin
        ndrop <= ndrop_calc;
        seen  <= '0;
      end
      S_EMIT: begin
        if (out_fire) begin
          idx  <= idx + SLOT_W'(1);
          seen <= seen + FILL_W'(verdict_mask[idx]);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### src/ifabd_checker.sv
// ----------------------------------------------------------------------------
// IPv4 adaptive burst drop filter: port checker
// Watches the top level's channels for ordering and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module ifabd_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 in_func,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire ifabd_pkg::out_item_t out_data
);
  import ifabd_pkg::*;

  // No result is shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // The block takes no new item while a result waits.
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // A tick produces its report in the next cycle.
  a_tick_report: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_func) |=> (out_valid && out_data.kind))
    else $error("tick without report");

  // Verdicts of one burst go out back to back with consecutive slots.
  a_slot_walk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.kind && !out_data.last) |=>
      (out_valid && !out_data.kind && (out_data.slot == $past(out_data.slot) + 5'd1)))
    else $error("verdict sequence broken");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind ipv4_filter_adaptive_burst_drop ifabd_checker u_ifabd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.data.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
